@@ rtl/core/rsst_pkg.sv @@
// Package for the range-sum segment tree.
// Holds shared constants, command codes and the result record type; no dependencies.
package rsst_pkg;

    localparam int LEAF_COUNT_DEF = 1024;
    localparam int SUM_W          = 32;

    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    error;
    } res_t;

endpackage

@@ rtl/core/range_sum_segment_tree.sv @@
// Top level of the range-sum segment tree: config register, node RAM, sequencer, result register.
// Depends on rsst_pkg, rsst_ram and rsst_seq.
//
//  port group  | dir | handshake           | payload
//  ------------+-----+---------------------+-----------------------------------------------
//  s_*         | in  | s_valid / s_ready   | s_command, s_first_index, s_last_index, s_new_value
//  m_*         | out | m_valid / m_ready   | m_range_sum, m_range_error
//  cfg_*       | in  | cfg_wr_en           | cfg_wr_data (terms in use)
//
// Assign: writes the leaf, then one tree level per cycle through the shared adder up to the root.
// Query: each level takes a left step (ST_QL) and a right step (ST_QR) on the one RAM read port.
// Reset and every config write start a clear pass over all 2*LEAF_COUNT nodes; s_ready stays low.
// Out-of-range assign beats are accepted and dropped; error queries return without reading the tree.
// A result waits in the output register; a finished query holds until that register frees.
module range_sum_segment_tree #(
    parameter int LEAF_COUNT = rsst_pkg::LEAF_COUNT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [$clog2(LEAF_COUNT):0]           cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_command,
    input  logic [$clog2(LEAF_COUNT)-1:0]         s_first_index,
    input  logic [$clog2(LEAF_COUNT)-1:0]         s_last_index,
    input  logic signed [rsst_pkg::SUM_W-1:0]     s_new_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rsst_pkg::SUM_W-1:0]     m_range_sum,
    output logic                                  m_range_error
);
    import rsst_pkg::*;

    localparam int IDX_W  = $clog2(LEAF_COUNT);
    localparam int NODE_W = IDX_W + 1;
    localparam int CFG_W  = IDX_W + 1;
    localparam int DEPTH  = 2 * LEAF_COUNT;

    logic [CFG_W-1:0]  terms_reg, terms_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg;

    logic              res_free;
    logic              res_valid;
    res_t              res;
    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    logic [SUM_W-1:0]  ram_wdata;
    logic [NODE_W-1:0] ram_raddr;
    logic [SUM_W-1:0]  ram_rdata;

    always_comb begin
        terms_next = terms_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                terms_next = CFG_W'(1);
            end else if (cfg_wr_data > CFG_W'(LEAF_COUNT)) begin
                terms_next = CFG_W'(LEAF_COUNT);
            end else begin
                terms_next = cfg_wr_data;
            end
        end
    end

    assign res_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            terms_reg   <= CFG_W'(LEAF_COUNT);
            m_valid_reg <= 1'b0;
        end else begin
            terms_reg   <= terms_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    rsst_seq #(
        .LEAF_COUNT(LEAF_COUNT)
    ) u_seq (
        .clk       (aclk),
        .rst_n     (aresetn),
        .clr_req   (cfg_wr_en),
        .terms     (terms_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_command(s_command),
        .in_first  (s_first_index),
        .in_last   (s_last_index),
        .in_value  (s_new_value),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    rsst_ram #(
        .WIDTH(SUM_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_range_sum   = m_res_reg.sum;
    assign m_range_error = m_res_reg.error;

endmodule

@@ rtl/core/rsst_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module rsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/rsst_seq.sv @@
// Sequencer and shared adder for the segment tree: clear pass, leaf assign with
// ancestor update, and bottom-up range query. Depends on rsst_pkg and drives rsst_ram.
module rsst_seq #(
    parameter int LEAF_COUNT = rsst_pkg::LEAF_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clr_req,
    input  logic [$clog2(LEAF_COUNT):0]          terms,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_command,
    input  logic [$clog2(LEAF_COUNT)-1:0]        in_first,
    input  logic [$clog2(LEAF_COUNT)-1:0]        in_last,
    input  logic [rsst_pkg::SUM_W-1:0]           in_value,
    input  logic                                 res_free,
    output logic                                 res_valid,
    output rsst_pkg::res_t                       res,
    output logic                                 ram_we,
    output logic [$clog2(LEAF_COUNT):0]          ram_waddr,
    output logic [rsst_pkg::SUM_W-1:0]           ram_wdata,
    output logic [$clog2(LEAF_COUNT):0]          ram_raddr,
    input  logic [rsst_pkg::SUM_W-1:0]           ram_rdata
);
    import rsst_pkg::*;

    localparam int IDX_W  = $clog2(LEAF_COUNT);
    localparam int NODE_W = IDX_W + 1;
    localparam int PTR_W  = NODE_W + 1;
    localparam int CFG_W  = IDX_W + 1;
    localparam int DEPTH  = 2 * LEAF_COUNT;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ALEAF = 3'd2;
    localparam logic [2:0] ST_AUP   = 3'd3;
    localparam logic [2:0] ST_QL    = 3'd4;
    localparam logic [2:0] ST_QR    = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [NODE_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0] k_reg, k_next;
    logic [PTR_W-1:0]  l_reg, l_next;
    logic [PTR_W-1:0]  r_reg, r_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic              pend_reg, pend_next;
    logic              err_reg, err_next;

    logic [SUM_W-1:0]  add_b;
    logic [SUM_W-1:0]  add_sum;
    logic [NODE_W-1:0] k_up;
    logic [NODE_W-1:0] leaf_k;
    logic [PTR_W-1:0]  l_start;
    logic [PTR_W-1:0]  r_start;
    logic              q_err;
    logic              asg_ok;

    assign add_b   = (state_reg == ST_AUP || pend_reg) ? ram_rdata : '0;
    assign add_sum = acc_reg + add_b;
    assign k_up    = k_reg >> 1;
    assign leaf_k  = NODE_W'(in_first) + NODE_W'(terms);
    assign l_start = PTR_W'(in_first) + PTR_W'(terms);
    assign r_start = PTR_W'(in_last) + PTR_W'(terms) + PTR_W'(1);
    assign q_err   = (CFG_W'(in_last) >= terms) || (in_first > in_last);
    assign asg_ok  = CFG_W'(in_first) < terms;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        acc_next     = acc_reg;
        pend_next    = 1'b0;
        err_next     = err_reg;
        ram_we       = 1'b0;
        ram_waddr    = k_reg;
        ram_wdata    = acc_reg;
        ram_raddr    = '0;
        res_valid    = 1'b0;
        res.sum      = add_sum;
        res.error    = err_reg;

        case (state_reg)
            ST_CLR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + NODE_W'(1);
                if (clr_cnt_reg == NODE_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_command == CMD_QUERY) begin
                        acc_next   = '0;
                        err_next   = q_err;
                        l_next     = q_err ? '0 : l_start;
                        r_next     = q_err ? '0 : r_start;
                        state_next = ST_QL;
                    end else if (asg_ok) begin
                        k_next     = leaf_k;
                        acc_next   = in_value;
                        state_next = ST_ALEAF;
                    end
                end
            end
            ST_ALEAF: begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg;
                ram_wdata  = acc_reg;
                ram_raddr  = k_reg ^ NODE_W'(1);
                state_next = (k_reg == NODE_W'(1)) ? ST_IDLE : ST_AUP;
            end
            ST_AUP: begin
                ram_we    = 1'b1;
                ram_waddr = k_up;
                ram_wdata = add_sum;
                acc_next  = add_sum;
                k_next    = k_up;
                ram_raddr = k_up ^ NODE_W'(1);
                if (k_up == NODE_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QL: begin
                acc_next = add_sum;
                if (l_reg < r_reg) begin
                    if (l_reg[0]) begin
                        ram_raddr = l_reg[NODE_W-1:0];
                        pend_next = 1'b1;
                        l_next    = l_reg + PTR_W'(1);
                    end
                    state_next = ST_QR;
                end else if (res_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_QR: begin
                acc_next = add_sum;
                if (r_reg[0]) begin
                    ram_raddr = {r_reg[NODE_W-1:1], 1'b0};
                    pend_next = 1'b1;
                end
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = ST_QL;
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase

        if (clr_req) begin
            state_next   = ST_CLR;
            clr_cnt_next = '0;
            pend_next    = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk) begin
        k_reg   <= k_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
        err_reg <= err_next;
    end

endmodule

@@ rtl/core/rsst_check.sv @@
// Port-level checker for the range-sum segment tree, bound to the top level.
// Depends on rsst_pkg and range_sum_segment_tree.
module rsst_check (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_wr_en,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_command,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [rsst_pkg::SUM_W-1:0]        m_range_sum,
    input logic                              m_range_error
);
    import rsst_pkg::*;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    a_cfg_clears: assert property (@(posedge aclk)
        cfg_wr_en |=> !s_ready)
        else $error("s_ready high right after config write");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_QUERY) |=> !s_ready)
        else $error("query beat did not make the block busy");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_range_error) |-> (m_range_sum == '0))
        else $error("error result with nonzero sum");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_range_sum)
                                   && $stable(m_range_error)))
        else $error("result beat changed while stalled");

endmodule

bind range_sum_segment_tree rsst_check u_rsst_check (.*);
